[rtl/oaht_pkg.sv]
// Shared types and constants for the open-addressing hash table.
// Used by every module of the block; depends on nothing.
package oaht_pkg;

   localparam int SLOTS = 256;
   localparam int IDX_W = $clog2(SLOTS);
   localparam int USED_W = $clog2(SLOTS + 1);
   localparam int CMP_W = ((USED_W > 8) ? USED_W : 8) + 1;
   localparam int KEY_W = 32;
   localparam int HASH_W = 32;
   localparam int VALUE_W = 64;
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   localparam logic [7:0] MAX_OCC_RESET = 8'd192;

   localparam logic [1:0] RES_OK = 2'd0;
   localparam logic [1:0] RES_MISSING = 2'd1;
   localparam logic [1:0] RES_FULL = 2'd2;

   localparam logic [1:0] REQ_GET = 2'd0;
   localparam logic [1:0] REQ_SET = 2'd1;
   localparam logic [1:0] REQ_DELETE = 2'd2;

   typedef enum logic [1:0] {
      OP_GET,
      OP_SET,
      OP_DELETE,
      OP_NONE
   } op_type;

   typedef enum logic [1:0] {
      ST_EMPTY,
      ST_LIVE,
      ST_TOMB
   } slot_stat_type;

   typedef enum logic [1:0] {
      ENG_IDLE,
      ENG_PROBE,
      ENG_CHECK,
      ENG_CLEAR
   } eng_state_type;

   typedef struct packed {
      op_type op;
      logic [KEY_W-1:0] key;
      logic [IDX_W-1:0] start;
      logic [VALUE_W-1:0] value;
   } req_item_type;

endpackage

[rtl/oaht_front.sv]
// Front stage of the hash table: accepts requests, decodes the operation
// and computes the first probe slot. Depends on oaht_pkg.
module oaht_front (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [1:0] req_type,
   input  logic [oaht_pkg::KEY_W-1:0] req_key_id,
   input  logic [oaht_pkg::HASH_W-1:0] req_key_hash,
   input  logic [oaht_pkg::VALUE_W-1:0] req_store_value,
   output logic push_valid,
   output oaht_pkg::req_item_type push_item,
   input  logic queue_full
);
   import oaht_pkg::*;

   logic fr_valid_ff, fr_valid_in;
   req_item_type fr_item_ff, fr_item_in;
   logic accept, push;
   op_type op_dec;

   always_comb begin
      case (req_type)
         REQ_GET: op_dec = OP_GET;
         REQ_SET: op_dec = OP_SET;
         REQ_DELETE: op_dec = OP_DELETE;
         default: op_dec = OP_NONE;
      endcase
   end

   assign push = fr_valid_ff && !queue_full;
   assign req_stall = fr_valid_ff && queue_full;
   assign accept = req_valid && !req_stall;

   always_comb begin
      fr_valid_in = fr_valid_ff;
      fr_item_in = fr_item_ff;
      if (push) begin
         fr_valid_in = 1'b0;
      end
      if (accept) begin
         fr_valid_in = 1'b1;
         fr_item_in.op = op_dec;
         fr_item_in.key = req_key_id;
         fr_item_in.start = req_key_hash[IDX_W-1:0];
         fr_item_in.value = req_store_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fr_valid_ff <= 1'b0;
      end else begin
         fr_valid_ff <= fr_valid_in;
      end
      fr_item_ff <= fr_item_in;
   end

   assign push_valid = push;
   assign push_item = fr_item_ff;

endmodule

[rtl/oaht_queue.sv]
// Short request queue between the front stage and the probe engine.
// Depends on oaht_pkg for the request type and the depth.
module oaht_queue (
   input  logic clock,
   input  logic reset,
   input  logic push_valid,
   input  oaht_pkg::req_item_type push_item,
   output logic queue_full,
   output logic pop_valid,
   output oaht_pkg::req_item_type pop_item,
   input  logic pop_ready
);
   import oaht_pkg::*;

   req_item_type entry_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign queue_full = (count_ff == Q_CNT_W'(Q_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_item = entry_ff[rd_ptr_ff];
   assign do_push = push_valid && !queue_full;
   assign do_pop = pop_ready && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[rtl/oaht_engine.sv]
// Probe engine of the hash table: clears the slot status after reset, walks the
// slots one by one, updates the slot store and holds the response register.
// Depends on oaht_pkg.
module oaht_engine (
   input  logic clock,
   input  logic reset,
   input  logic [7:0] max_occupied,
   input  logic pop_valid,
   input  oaht_pkg::req_item_type pop_item,
   output logic pop_ready,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [1:0] rsp_status,
   output logic [oaht_pkg::VALUE_W-1:0] rsp_read_value,
   output logic rsp_new_entry
);
   import oaht_pkg::*;

   logic [KEY_W-1:0] key_mem [SLOTS];
   logic [VALUE_W-1:0] value_mem [SLOTS];
   slot_stat_type status_mem [SLOTS];
   logic [USED_W-1:0] used_ff, used_in;

   eng_state_type state_ff, state_in;
   req_item_type cur_ff, cur_in;
   logic [IDX_W-1:0] idx_ff, idx_in, cnt_ff, cnt_in, tomb_idx_ff, tomb_idx_in;
   logic have_tomb_ff, have_tomb_in;

   slot_stat_type rd_stat_ff;
   logic rd_live, rd_tomb;
   logic [KEY_W-1:0] rd_key_ff;
   logic [VALUE_W-1:0] rd_value_ff;

   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic rsp_new_ff, rsp_new_in;

   logic out_free, hit, empty, last, finish, advance, fire, place, fresh, bypass;
   logic clear_last;
   logic [IDX_W-1:0] pos;
   logic wr_key_en, wr_value_en, mark_live, mark_tomb;
   logic [IDX_W-1:0] wr_addr;
   logic [1:0] res_status;
   logic [VALUE_W-1:0] res_value;
   logic res_new;

   assign rd_live = (rd_stat_ff == ST_LIVE);
   assign rd_tomb = (rd_stat_ff == ST_TOMB);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign hit = rd_live && (rd_key_ff == cur_ff.key);
   assign empty = !rd_live && !rd_tomb;
   assign last = (cnt_ff == IDX_W'(SLOTS - 1));
   assign clear_last = (idx_ff == IDX_W'(SLOTS - 1));

   // Probe decision and the resulting response and store update.
   always_comb begin
      finish = 1'b0;
      advance = 1'b0;
      place = 1'b0;
      fresh = 1'b0;
      pos = idx_ff;
      if (state_ff == ENG_CHECK) begin
         if (hit) begin
            finish = 1'b1;
         end else if (empty) begin
            finish = 1'b1;
            place = 1'b1;
            fresh = !have_tomb_ff;
            pos = have_tomb_ff ? tomb_idx_ff : idx_ff;
         end else if (last) begin
            finish = 1'b1;
            place = have_tomb_ff || rd_tomb;
            pos = have_tomb_ff ? tomb_idx_ff : idx_ff;
         end else begin
            advance = 1'b1;
         end
      end

      res_status = RES_MISSING;
      res_value = '0;
      res_new = 1'b0;
      wr_key_en = 1'b0;
      wr_value_en = 1'b0;
      mark_live = 1'b0;
      mark_tomb = 1'b0;
      wr_addr = idx_ff;
      case (cur_ff.op)
         OP_GET: begin
            if (hit) begin
               res_status = RES_OK;
               res_value = rd_value_ff;
            end
         end
         OP_SET: begin
            if (hit) begin
               res_status = RES_OK;
               wr_value_en = 1'b1;
            end else if (place) begin
               wr_addr = pos;
               if (fresh && ((CMP_W'(used_ff) + CMP_W'(1)) > CMP_W'(max_occupied))) begin
                  res_status = RES_FULL;
               end else begin
                  res_status = RES_OK;
                  res_new = 1'b1;
                  wr_key_en = 1'b1;
                  wr_value_en = 1'b1;
                  mark_live = 1'b1;
               end
            end else begin
               res_status = RES_FULL;
            end
         end
         OP_DELETE: begin
            if (hit) begin
               res_status = RES_OK;
               mark_tomb = 1'b1;
            end
         end
         default: begin
            res_status = RES_MISSING;
         end
      endcase
   end

   // Handshake and response register control.
   always_comb begin
      bypass = (state_ff == ENG_IDLE) && pop_valid && (pop_item.op == OP_NONE);
      fire = finish && out_free;
      pop_ready = (state_ff == ENG_IDLE) && (!bypass || out_free);

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_value_in = rsp_value_ff;
      rsp_new_in = rsp_new_ff;
      if (bypass && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_status_in = RES_MISSING;
         rsp_value_in = '0;
         rsp_new_in = 1'b0;
      end else if (fire) begin
         rsp_valid_in = 1'b1;
         rsp_status_in = res_status;
         rsp_value_in = res_value;
         rsp_new_in = res_new;
      end

      used_in = used_ff;
      if (fire && mark_live && fresh) begin
         used_in = used_ff + 1'b1;
      end

      cur_in = cur_ff;
      idx_in = idx_ff;
      cnt_in = cnt_ff;
      have_tomb_in = have_tomb_ff;
      tomb_idx_in = tomb_idx_ff;
      if (state_ff == ENG_CLEAR) begin
         idx_in = idx_ff + 1'b1;
      end else if ((state_ff == ENG_IDLE) && pop_valid && !bypass) begin
         cur_in = pop_item;
         idx_in = pop_item.start;
         cnt_in = '0;
         have_tomb_in = 1'b0;
      end else if (advance) begin
         idx_in = idx_ff + 1'b1;
         cnt_in = cnt_ff + 1'b1;
         if (rd_tomb && !have_tomb_ff) begin
            have_tomb_in = 1'b1;
            tomb_idx_in = idx_ff;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ENG_CLEAR: begin
            if (clear_last) begin
               state_in = ENG_IDLE;
            end
         end
         ENG_IDLE: begin
            if (pop_valid && !bypass) begin
               state_in = ENG_PROBE;
            end
         end
         ENG_PROBE: begin
            state_in = ENG_CHECK;
         end
         ENG_CHECK: begin
            if (fire) begin
               state_in = ENG_IDLE;
            end else if (advance) begin
               state_in = ENG_PROBE;
            end
         end
         default: begin
            state_in = ENG_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ENG_CLEAR;
         idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
         used_ff <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         used_ff <= used_in;
      end
      cur_ff <= cur_in;
      cnt_ff <= cnt_in;
      have_tomb_ff <= have_tomb_in;
      tomb_idx_ff <= tomb_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff <= rsp_value_in;
      rsp_new_ff <= rsp_new_in;
   end

   always_ff @(posedge clock) begin
      if (state_ff == ENG_PROBE) begin
         rd_key_ff <= key_mem[idx_ff];
         rd_value_ff <= value_mem[idx_ff];
         rd_stat_ff <= status_mem[idx_ff];
      end
      if (state_ff == ENG_CLEAR) begin
         status_mem[idx_ff] <= ST_EMPTY;
      end else if (fire && mark_live) begin
         status_mem[wr_addr] <= ST_LIVE;
      end else if (fire && mark_tomb) begin
         status_mem[wr_addr] <= ST_TOMB;
      end
      if (fire && wr_key_en) begin
         key_mem[wr_addr] <= cur_ff.key;
      end
      if (fire && wr_value_en) begin
         value_mem[wr_addr] <= cur_ff.value;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_new_entry = rsp_new_ff;

   a_used_bounded: assert property (@(posedge clock) disable iff (reset)
      used_ff <= USED_W'(SLOTS))
      else $error("Used count exceeds the slot count.");

   a_no_pop_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ENG_CLEAR) |-> !pop_ready)
      else $error("Request taken while the slot status is being cleared.");

   a_check_after_probe: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ENG_CHECK) |->
         ($past(state_ff) == ENG_PROBE || $past(state_ff) == ENG_CHECK))
      else $error("Slot check without a preceding slot read.");

   a_update_with_response: assert property (@(posedge clock) disable iff (reset)
      (fire && (wr_value_en || mark_tomb)) |=> rsp_valid_ff)
      else $error("Store updated without a response.");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=>
         (rsp_valid_ff && $stable(rsp_status_ff) && $stable(rsp_value_ff)
          && $stable(rsp_new_ff)))
      else $error("Stalled response changed.");

endmodule

[rtl/open_addressing_hash_table_top.sv]
// Top level of the open-addressing hash table with linear probing.
// Instantiates oaht_front, oaht_queue and oaht_engine; depends on oaht_pkg.
//
// Requests (req_) carry an operation, a key identity, its hash and a value;
// each request yields exactly one response (rsp_) with a status, the value
// read by a get and a flag that a set created a new entry. Both channels use
// valid and stall: an item moves at a clock edge with valid high and stall
// low. csr_write loads csr_data into the occupancy limit for sets.
// A request passes a front register and a two-entry queue; the engine then
// starts it from its idle state and probes each slot with a registered memory
// read (probe state) followed by a compare (check state). An unknown operation
// is answered from the idle state without a probe. The front and the queue
// hold up to three more requests.
// A stalled response is held in the output register; the engine keeps the
// finished request until that register is free, and req_stall rises once
// the queue and front register are full.
// After reset the engine clears the slot status one slot per cycle before it
// takes a request; the used count is zeroed and the limit is loaded with 192.
module open_addressing_hash_table_top (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [1:0] req_type,
   input  logic [oaht_pkg::KEY_W-1:0] req_key_id,
   input  logic [oaht_pkg::HASH_W-1:0] req_key_hash,
   input  logic [oaht_pkg::VALUE_W-1:0] req_store_value,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [1:0] rsp_status,
   output logic [oaht_pkg::VALUE_W-1:0] rsp_read_value,
   output logic rsp_new_entry,
   input  logic csr_write,
   input  logic [7:0] csr_data
);
   import oaht_pkg::*;

   logic [7:0] max_occ_ff;
   logic push_valid, queue_full, pop_valid, pop_ready;
   req_item_type push_item, pop_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_occ_ff <= MAX_OCC_RESET;
      end else if (csr_write) begin
         max_occ_ff <= csr_data;
      end
   end

   oaht_front u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_type(req_type),
      .req_key_id(req_key_id),
      .req_key_hash(req_key_hash),
      .req_store_value(req_store_value),
      .push_valid(push_valid),
      .push_item(push_item),
      .queue_full(queue_full)
   );

   oaht_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push_valid(push_valid),
      .push_item(push_item),
      .queue_full(queue_full),
      .pop_valid(pop_valid),
      .pop_item(pop_item),
      .pop_ready(pop_ready)
   );

   oaht_engine u_engine (
      .clock(clock),
      .reset(reset),
      .max_occupied(max_occ_ff),
      .pop_valid(pop_valid),
      .pop_item(pop_item),
      .pop_ready(pop_ready),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_read_value(rsp_read_value),
      .rsp_new_entry(rsp_new_entry)
   );

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// Testbench for open_addressing_hash_table_top. It sends get, set, delete and unknown-operation requests,
// predicts each response from its own copy of the slot table, and checks every response.
// Depends on oaht_pkg and the top-level RTL only.
module testbench;
   import oaht_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int IDLE_PCT = 37;
   localparam int POOL_MAX = 64;

   typedef struct packed {
      logic [1:0] status;
      logic [VALUE_W-1:0] read_value;
      logic is_new;
   } table_result_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [1:0] req_type;
   logic [KEY_W-1:0] req_key_id;
   logic [HASH_W-1:0] req_key_hash;
   logic [VALUE_W-1:0] req_store_value;
   logic rsp_valid;
   logic rsp_stall;
   logic [1:0] rsp_status;
   logic [VALUE_W-1:0] rsp_read_value;
   logic rsp_new_entry;
   logic csr_write;
   logic [7:0] csr_data;

   slot_stat_type model_state[SLOTS];
   logic [KEY_W-1:0] model_key[SLOTS];
   logic [VALUE_W-1:0] model_value[SLOTS];
   int model_used;
   logic [7:0] model_limit;

   table_result_type pending_results[$];
   int mismatch_count;
   int requests_sent;
   int results_checked;
   int quiet_cycles;
   bit steady;

   logic [KEY_W-1:0] key_pool[POOL_MAX];
   logic [IDX_W-1:0] key_home[POOL_MAX];

   open_addressing_hash_table_top u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_type(req_type),
      .req_key_id(req_key_id),
      .req_key_hash(req_key_hash),
      .req_store_value(req_store_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_read_value(rsp_read_value),
      .rsp_new_entry(rsp_new_entry),
      .csr_write(csr_write),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Linear probe from the hash's low bits, then apply the operation to the table copy.
   function automatic table_result_type predict_access(input op_type op,
         input logic [KEY_W-1:0] key, input logic [HASH_W-1:0] hash,
         input logic [VALUE_W-1:0] value);
      table_result_type res;
      logic [IDX_W-1:0] idx;
      logic [IDX_W-1:0] pos;
      logic [IDX_W-1:0] tomb;
      bit have_tomb;
      bit found;
      bit has_place;
      bit fresh;
      int n;
      res.status = RES_MISSING;
      res.read_value = '0;
      res.is_new = 1'b0;
      if (op == OP_NONE)
         return res;
      idx = hash[IDX_W-1:0];
      pos = '0;
      tomb = '0;
      have_tomb = 1'b0;
      found = 1'b0;
      has_place = 1'b0;
      for (n = 0; n < SLOTS && !found && !has_place; n++) begin
         case (model_state[idx])
            ST_EMPTY: begin
               has_place = 1'b1;
               pos = have_tomb ? tomb : idx;
            end
            ST_TOMB: begin
               if (!have_tomb) begin
                  have_tomb = 1'b1;
                  tomb = idx;
               end
            end
            default: begin
               if (model_key[idx] == key) begin
                  found = 1'b1;
                  pos = idx;
               end
            end
         endcase
         idx = idx + 1'b1;
      end
      if (!found && !has_place && have_tomb) begin
         has_place = 1'b1;
         pos = tomb;
      end
      case (op)
         OP_GET: begin
            if (found) begin
               res.status = RES_OK;
               res.read_value = model_value[pos];
            end
         end
         OP_SET: begin
            if (found) begin
               model_value[pos] = value;
               res.status = RES_OK;
            end else if (!has_place) begin
               res.status = RES_FULL;
            end else begin
               fresh = (model_state[pos] == ST_EMPTY);
               if (fresh && model_used + 1 > model_limit) begin
                  res.status = RES_FULL;
               end else begin
                  if (fresh)
                     model_used++;
                  model_state[pos] = ST_LIVE;
                  model_key[pos] = key;
                  model_value[pos] = value;
                  res.status = RES_OK;
                  res.is_new = 1'b1;
               end
            end
         end
         OP_DELETE: begin
            if (found) begin
               model_state[pos] = ST_TOMB;
               res.status = RES_OK;
            end
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   task automatic note_mismatch(input string what, input logic [63:0] want,
         input logic [63:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("testbench: mismatch at %0t on %s: expected %h, got %h",
                  $time, what, want, got);
   endtask

   // The request stays valid from one acceptance to the next unless a gap is drawn.
   task automatic send_request(input op_type op, input logic [KEY_W-1:0] key,
         input logic [HASH_W-1:0] hash, input logic [VALUE_W-1:0] value);
      if (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         do
            @(posedge clock);
         while ($urandom_range(99) < IDLE_PCT);
      end
      req_valid <= 1'b1;
      req_type <= op;
      req_key_id <= key;
      req_key_hash <= hash;
      req_store_value <= value;
      pending_results.push_back(predict_access(op, key, hash, value));
      requests_sent++;
      do
         @(posedge clock);
      while (req_stall);
   endtask

   task automatic drain_requests();
      req_valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_limit(input logic [7:0] limit);
      drain_requests();
      csr_write <= 1'b1;
      csr_data <= limit;
      @(posedge clock);
      csr_write <= 1'b0;
      model_limit = limit;
   endtask

   // Keys come from a pool with fixed home slots so that sets, gets and deletes meet
   // each other, except for a fresh_pct share of fresh keys with arbitrary hashes.
   task automatic random_traffic(input int count, input int pool_size, input int home_span,
         input int fresh_pct, input int burst_len);
      logic [IDX_W-1:0] base;
      logic [KEY_W-1:0] key;
      logic [HASH_W-1:0] hash;
      op_type op;
      int pick;
      int roll;
      int i;
      base = IDX_W'($urandom_range(SLOTS - 1));
      for (i = 0; i < pool_size; i++) begin
         if (i == 0)
            key_pool[i] = {KEY_W{1'b0}};
         else if (i == 1)
            key_pool[i] = {KEY_W{1'b1}};
         else
            key_pool[i] = $urandom;
         key_home[i] = IDX_W'(base + $urandom_range(home_span - 1));
      end
      for (i = 0; i < count; i++) begin
         steady = (i < burst_len);
         roll = $urandom_range(99);
         if (roll < 5)
            op = OP_NONE;
         else if (roll < 45)
            op = OP_SET;
         else if (roll < 78)
            op = OP_GET;
         else
            op = OP_DELETE;
         if ($urandom_range(99) < fresh_pct) begin
            key = $urandom;
            hash = $urandom;
         end else begin
            pick = $urandom_range(pool_size - 1);
            key = key_pool[pick];
            hash = $urandom;
            hash[IDX_W-1:0] = key_home[pick];
         end
         send_request(op, key, hash, {$urandom, $urandom});
      end
      steady = 1'b0;
   endtask

   task automatic test_directed_basics();
      send_request(OP_GET, 32'h0000_0005, 32'h0000_0010, 64'h0);
      send_request(OP_DELETE, 32'h0000_0005, 32'h0000_0010, 64'h0);
      send_request(OP_SET, 32'h0000_0000, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      send_request(OP_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h0);
      send_request(OP_GET, 32'h0000_0000, 32'hFFFF_FFFF, 64'h0);
      send_request(OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h0);
      send_request(OP_SET, 32'h0000_0000, 32'hFFFF_FFFF, 64'h0123_4567_89AB_CDEF);
      send_request(OP_GET, 32'h0000_0000, 32'hFFFF_FFFF, 64'h0);
      send_request(OP_DELETE, 32'h0000_0000, 32'hFFFF_FFFF, 64'h0);
      send_request(OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h0);
      send_request(OP_SET, 32'h0000_0007, 32'hFFFF_FFFF, 64'hA5A5_A5A5_5A5A_5A5A);
      send_request(OP_DELETE, 32'h0000_0000, 32'hFFFF_FFFF, 64'h0);
      send_request(OP_NONE, $urandom, $urandom, {$urandom, $urandom});
   endtask

   task automatic test_occupancy_limits();
      write_limit(8'd0);
      send_request(OP_SET, 32'h0000_0009, 32'h0000_0020, {$urandom, $urandom});
      send_request(OP_SET, 32'h0000_0007, 32'hFFFF_FFFF, {$urandom, $urandom});
      send_request(OP_DELETE, 32'h0000_0007, 32'hFFFF_FFFF, 64'h0);
      send_request(OP_SET, 32'h0000_0008, 32'hFFFF_FFFF, {$urandom, $urandom});
      write_limit(8'd1);
      send_request(OP_SET, 32'h0000_0009, 32'h0000_0020, {$urandom, $urandom});
      write_limit(8'd3);
      send_request(OP_SET, 32'h0000_0009, 32'h0000_0020, {$urandom, $urandom});
      send_request(OP_SET, 32'h0000_000A, 32'h0000_0020, {$urandom, $urandom});
      send_request(OP_GET, 32'h0000_0009, 32'h0000_0020, 64'h0);
   endtask

   task automatic test_random_clustered();
      write_limit(8'd40);
      random_traffic(250, 24, 6, 10, 0);
   endtask

   task automatic test_random_default_limit();
      write_limit(MAX_OCC_RESET);
      random_traffic(350, 64, SLOTS, 15, 150);
   endtask

   task automatic test_random_full_table();
      write_limit(8'd255);
      random_traffic(350, 64, 48, 50, 0);
   endtask

   always @(posedge clock) begin
      rsp_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
   end

   always @(posedge clock) begin
      table_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_checked++;
         if (pending_results.size() == 0) begin
            note_mismatch("response with no request outstanding", 64'h0,
                          64'(rsp_status));
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status)
               note_mismatch("status", 64'(want.status), 64'(rsp_status));
            if (rsp_read_value !== want.read_value)
               note_mismatch("read_value", want.read_value, rsp_read_value);
            if (rsp_new_entry !== want.is_new)
               note_mismatch("new_entry", 64'(want.is_new), 64'(rsp_new_entry));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("testbench: no progress for %0d cycles, %0d responses outstanding",
                  quiet_cycles, pending_results.size());
         $display("testbench: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_type = REQ_GET;
      req_key_id = '0;
      req_key_hash = '0;
      req_store_value = '0;
      rsp_stall = 1'b0;
      csr_write = 1'b0;
      csr_data = MAX_OCC_RESET;
      steady = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
         model_state[i] = ST_EMPTY;
         model_key[i] = '0;
         model_value[i] = '0;
      end
      model_used = 0;
      model_limit = MAX_OCC_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed_basics();
      test_occupancy_limits();
      test_random_clustered();
      test_random_default_limit();
      test_random_full_table();
      drain_requests();
      repeat (20) @(posedge clock);
      $display("testbench: %0d requests sent, %0d responses checked, %0d mismatches",
               requests_sent, results_checked, mismatch_count);
      $display("testbench: limits 0 to 255 exercised, %0d of %0d slots used or deleted",
               model_used, SLOTS);
      if (mismatch_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule

[files.f]
rtl/oaht_pkg.sv
rtl/oaht_front.sv
rtl/oaht_queue.sv
rtl/oaht_engine.sv
rtl/open_addressing_hash_table_top.sv
tb/sv/testbench.sv
